// ===== rtl/lavm_pkg.sv =====
// Shared row codes for the look-at view matrix block.
package lavm_pkg;

   typedef enum logic [1:0] {
      ROW_LEFT = 2'd0,
      ROW_UP   = 2'd1,
      ROW_FWD  = 2'd2,
      ROW_LAST = 2'd3
   } row_type;

endpackage

// ===== rtl/look_at_view_matrix.sv =====
// Look-at view matrix builder: pipelined normalize, cross and dot products, row serializer.
//
//   channel | direction | handshake            | beat
//   req_    | in        | req_valid/req_stall  | eye, target, upward (Q fixed point)
//   rsp_    | out       | rsp_valid/rsp_stall  | one matrix row, four beats per item
//
// One item yields four rsp beats; the serializer takes the next item from the last stage
// only as the last row of the previous one drains, so the single rsp channel sets intake.
// The pipeline holds 31 square-root bit stages and FRAC_BITS + 2 divider bit stages.
// Reset clears all pipeline valid bits and the serializer; payload is not reset.
// The whole pipeline freezes only when the last stage holds an item that the serializer
// cannot take, as it is still draining rows or rsp_stall holds them; req_stall follows.
module look_at_view_matrix #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_eye_x,
   input  logic signed [31:0] req_eye_y,
   input  logic signed [31:0] req_eye_z,
   input  logic signed [31:0] req_target_x,
   input  logic signed [31:0] req_target_y,
   input  logic signed [31:0] req_target_z,
   input  logic signed [31:0] req_upward_x,
   input  logic signed [31:0] req_upward_y,
   input  logic signed [31:0] req_upward_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_row_index,
   output logic signed [31:0] rsp_col0,
   output logic signed [31:0] rsp_col1,
   output logic signed [31:0] rsp_col2,
   output logic signed [31:0] rsp_col3,
   output logic               rsp_degenerate,
   output logic               rsp_saturated,
   output logic               rsp_last_row
);

   localparam int QW  = FRAC_BITS + 2;
   localparam int VW  = FRAC_BITS + 3;
   localparam int PW  = 2 * VW;
   localparam int CW  = PW + 1;
   localparam int EW  = VW + 32;
   localparam int SW  = EW + 2;
   localparam int DRW = SW + 1 - FRAC_BITS;

   localparam int ST_IN   = 0;
   localparam int ST_ABS  = 1;
   localparam int ST_MAX  = 2;
   localparam int ST_POS  = 3;
   localparam int ST_NORM = 4;
   localparam int ST_SQ   = 5;
   localparam int ST_SUM  = 6;
   localparam int ST_RT0  = 7;
   localparam int RT_N    = 31;
   localparam int ST_DV0  = ST_RT0 + RT_N;
   localparam int ST_UNIT = ST_DV0 + QW;
   localparam int ST_C1M  = ST_UNIT + 1;
   localparam int ST_C1D  = ST_C1M + 1;
   localparam int ST_C1R  = ST_C1D + 1;
   localparam int ST_C2M  = ST_C1R + 1;
   localparam int ST_C2D  = ST_C2M + 1;
   localparam int ST_C2R  = ST_C2D + 1;
   localparam int ST_DM   = ST_C2R + 1;
   localparam int ST_DS   = ST_DM + 1;
   localparam int ST_DR   = ST_DS + 1;
   localparam int ST_SAT  = ST_DR + 1;
   localparam int NST     = ST_SAT + 1;

   localparam logic [CW:0] HALF_C =
      {{(CW + 1 - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
   localparam logic [SW:0] HALF_S =
      {{(SW + 1 - FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS - 1){1'b0}}};
   localparam logic signed [DRW:0] TR_MAX = {{(DRW - 30){1'b0}}, {31{1'b1}}};
   localparam logic signed [DRW:0] TR_MIN = {{(DRW - 30){1'b1}}, {31{1'b0}}};
   localparam logic signed [31:0]  ONE    =
      {{(32 - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

   typedef struct {
      logic signed [31:0]     eye  [3];
      logic signed [32:0]     vin  [6];
      logic                   sgn  [6];
      logic [31:0]            mag  [6];
      logic [31:0]            mx   [2];
      logic [4:0]             pos  [2];
      logic                   degen;
      logic [29:0]            nrm  [6];
      logic [59:0]            sq   [6];
      logic [61:0]            rad  [2];
      logic [31:0]            rem  [2];
      logic [30:0]            root [2];
      logic [31:0]            rr   [6];
      logic [QW-1:0]          qt   [6];
      logic signed [VW-1:0]   u    [6];
      logic signed [PW-1:0]   pr   [6];
      logic signed [CW-1:0]   cd   [3];
      logic signed [VW-1:0]   lf   [3];
      logic signed [VW-1:0]   tu   [3];
      logic signed [EW-1:0]   dp   [9];
      logic signed [SW-1:0]   ds   [3];
      logic signed [DRW-1:0]  dr   [3];
      logic signed [31:0]     tr   [3];
      logic                   sat  [3];
   } pipe_type;

   function automatic logic signed [VW-1:0] rnd_c(input logic signed [CW-1:0] x);
      logic [CW:0] e;
      e = {x[CW-1], x} + HALF_C - {{CW{1'b0}}, x[CW-1]};
      return e[FRAC_BITS +: VW];
   endfunction

   function automatic logic signed [DRW-1:0] rnd_s(input logic signed [SW-1:0] x);
      logic [SW:0] e;
      e = {x[SW-1], x} + HALF_S - {{SW{1'b0}}, x[SW-1]};
      return e[FRAC_BITS +: DRW];
   endfunction

   pipe_type         st_ff [NST];
   pipe_type         st_in [NST];
   logic [NST-1:0]   vld_ff;
   logic             adv;
   logic             ser_rdy;
   logic             take;
   pipe_type         ser_ff;
   logic             ser_vld_ff;
   lavm_pkg::row_type row_ff;

   assign ser_rdy   = !ser_vld_ff || (row_ff == lavm_pkg::ROW_LAST && !rsp_stall);
   assign take      = vld_ff[NST-1] && ser_rdy;
   assign adv       = ser_rdy || !vld_ff[NST-1];
   assign req_stall = !adv;

   for (genvar k = 0; k < NST; k++) begin : g_stage
      if (k == ST_IN) begin : g_in
         always_comb begin
            st_in[k] = st_ff[k];
            st_in[k].eye[0] = req_eye_x;
            st_in[k].eye[1] = req_eye_y;
            st_in[k].eye[2] = req_eye_z;
            st_in[k].vin[0] = {req_target_x[31], req_target_x} - {req_eye_x[31], req_eye_x};
            st_in[k].vin[1] = {req_target_y[31], req_target_y} - {req_eye_y[31], req_eye_y};
            st_in[k].vin[2] = {req_target_z[31], req_target_z} - {req_eye_z[31], req_eye_z};
            st_in[k].vin[3] = {req_upward_x[31], req_upward_x};
            st_in[k].vin[4] = {req_upward_y[31], req_upward_y};
            st_in[k].vin[5] = {req_upward_z[31], req_upward_z};
         end
      end else if (k == ST_ABS) begin : g_abs
         always_comb begin
            st_in[k] = st_ff[k-1];
            for (int i = 0; i < 6; i++) begin
               st_in[k].sgn[i] = st_ff[k-1].vin[i][32];
               st_in[k].mag[i] = st_ff[k-1].vin[i][32] ? 32'(-st_ff[k-1].vin[i])
                                                        : st_ff[k-1].vin[i][31:0];
            end
         end
      end else if (k == ST_MAX) begin : g_max
         always_comb begin
            logic [31:0] m;
            st_in[k] = st_ff[k-1];
            for (int j = 0; j < 2; j++) begin
               m = st_ff[k-1].mag[3*j];
               if (st_ff[k-1].mag[3*j+1] > m) m = st_ff[k-1].mag[3*j+1];
               if (st_ff[k-1].mag[3*j+2] > m) m = st_ff[k-1].mag[3*j+2];
               st_in[k].mx[j] = m;
            end
         end
      end else if (k == ST_POS) begin : g_pos
         always_comb begin
            logic [4:0] p;
            st_in[k] = st_ff[k-1];
            for (int j = 0; j < 2; j++) begin
               p = '0;
               for (int b = 0; b < 32; b++) begin
                  if (st_ff[k-1].mx[j][b]) p = 5'(b);
               end
               st_in[k].pos[j] = p;
            end
            st_in[k].degen = (st_ff[k-1].mx[0] == '0) || (st_ff[k-1].mx[1] == '0);
         end
      end else if (k == ST_NORM) begin : g_norm
         always_comb begin
            logic [4:0] p;
            st_in[k] = st_ff[k-1];
            for (int i = 0; i < 6; i++) begin
               p = (i < 3) ? st_ff[k-1].pos[0] : st_ff[k-1].pos[1];
               if (p >= 5'd29) st_in[k].nrm[i] = 30'(st_ff[k-1].mag[i] >> (p - 5'd29));
               else            st_in[k].nrm[i] = 30'(st_ff[k-1].mag[i] << (5'd29 - p));
            end
         end
      end else if (k == ST_SQ) begin : g_sq
         always_comb begin
            st_in[k] = st_ff[k-1];
            for (int i = 0; i < 6; i++) begin
               st_in[k].sq[i] = st_ff[k-1].nrm[i] * st_ff[k-1].nrm[i];
            end
         end
      end else if (k == ST_SUM) begin : g_sum
         always_comb begin
            st_in[k] = st_ff[k-1];
            for (int j = 0; j < 2; j++) begin
               st_in[k].rad[j] = 62'(st_ff[k-1].sq[3*j]) + 62'(st_ff[k-1].sq[3*j+1])
                               + 62'(st_ff[k-1].sq[3*j+2]);
               st_in[k].rem[j]  = '0;
               st_in[k].root[j] = '0;
            end
         end
      end else if (k >= ST_RT0 && k < ST_DV0) begin : g_rt
         always_comb begin
            logic [33:0] t;
            logic [33:0] trial;
            logic        b;
            st_in[k] = st_ff[k-1];
            for (int j = 0; j < 2; j++) begin
               t     = {st_ff[k-1].rem[j], st_ff[k-1].rad[j][61:60]};
               trial = {1'b0, st_ff[k-1].root[j], 2'b01};
               b     = t >= trial;
               st_in[k].rem[j]  = b ? 32'(t - trial) : t[31:0];
               st_in[k].root[j] = {st_ff[k-1].root[j][29:0], b};
               st_in[k].rad[j]  = {st_ff[k-1].rad[j][59:0], 2'b00};
            end
         end
      end else if (k == ST_DV0) begin : g_dv0
         always_comb begin
            logic [30:0] l;
            logic        b;
            st_in[k] = st_ff[k-1];
            for (int i = 0; i < 6; i++) begin
               l = (i < 3) ? st_ff[k-1].root[0] : st_ff[k-1].root[1];
               b = {1'b0, st_ff[k-1].nrm[i]} >= l;
               st_in[k].rr[i] = b ? 32'({2'b00, st_ff[k-1].nrm[i]} - {1'b0, l})
                                  : {2'b00, st_ff[k-1].nrm[i]};
               st_in[k].qt[i] = {st_ff[k-1].qt[i][QW-2:0], b};
            end
         end
      end else if (k > ST_DV0 && k < ST_UNIT) begin : g_dv
         always_comb begin
            logic [30:0] l;
            logic [32:0] t;
            logic        b;
            st_in[k] = st_ff[k-1];
            for (int i = 0; i < 6; i++) begin
               l = (i < 3) ? st_ff[k-1].root[0] : st_ff[k-1].root[1];
               t = {st_ff[k-1].rr[i], 1'b0};
               b = t >= {2'b00, l};
               st_in[k].rr[i] = b ? 32'(t - {2'b00, l}) : t[31:0];
               st_in[k].qt[i] = {st_ff[k-1].qt[i][QW-2:0], b};
            end
         end
      end else if (k == ST_UNIT) begin : g_unit
         always_comb begin
            logic [QW:0] qq;
            st_in[k] = st_ff[k-1];
            for (int i = 0; i < 6; i++) begin
               qq = ({1'b0, st_ff[k-1].qt[i]} + {{QW{1'b0}}, 1'b1}) >> 1;
               st_in[k].u[i] = st_ff[k-1].sgn[i] ? -qq : qq;
            end
         end
      end else if (k == ST_C1M) begin : g_c1m
         always_comb begin
            st_in[k] = st_ff[k-1];
            st_in[k].pr[0] = st_ff[k-1].u[1] * st_ff[k-1].u[5];
            st_in[k].pr[1] = st_ff[k-1].u[2] * st_ff[k-1].u[4];
            st_in[k].pr[2] = st_ff[k-1].u[2] * st_ff[k-1].u[3];
            st_in[k].pr[3] = st_ff[k-1].u[0] * st_ff[k-1].u[5];
            st_in[k].pr[4] = st_ff[k-1].u[0] * st_ff[k-1].u[4];
            st_in[k].pr[5] = st_ff[k-1].u[1] * st_ff[k-1].u[3];
         end
      end else if (k == ST_C2M) begin : g_c2m
         always_comb begin
            st_in[k] = st_ff[k-1];
            st_in[k].pr[0] = st_ff[k-1].lf[1] * st_ff[k-1].u[2];
            st_in[k].pr[1] = st_ff[k-1].lf[2] * st_ff[k-1].u[1];
            st_in[k].pr[2] = st_ff[k-1].lf[2] * st_ff[k-1].u[0];
            st_in[k].pr[3] = st_ff[k-1].lf[0] * st_ff[k-1].u[2];
            st_in[k].pr[4] = st_ff[k-1].lf[0] * st_ff[k-1].u[1];
            st_in[k].pr[5] = st_ff[k-1].lf[1] * st_ff[k-1].u[0];
         end
      end else if (k == ST_C1D || k == ST_C2D) begin : g_cd
         always_comb begin
            st_in[k] = st_ff[k-1];
            for (int i = 0; i < 3; i++) begin
               st_in[k].cd[i] = st_ff[k-1].pr[2*i] - st_ff[k-1].pr[2*i+1];
            end
         end
      end else if (k == ST_C1R) begin : g_c1r
         always_comb begin
            st_in[k] = st_ff[k-1];
            for (int i = 0; i < 3; i++) st_in[k].lf[i] = rnd_c(st_ff[k-1].cd[i]);
         end
      end else if (k == ST_C2R) begin : g_c2r
         always_comb begin
            st_in[k] = st_ff[k-1];
            for (int i = 0; i < 3; i++) st_in[k].tu[i] = rnd_c(st_ff[k-1].cd[i]);
         end
      end else if (k == ST_DM) begin : g_dm
         always_comb begin
            st_in[k] = st_ff[k-1];
            for (int i = 0; i < 3; i++) begin
               st_in[k].dp[i]   = st_ff[k-1].lf[i] * st_ff[k-1].eye[i];
               st_in[k].dp[3+i] = st_ff[k-1].tu[i] * st_ff[k-1].eye[i];
               st_in[k].dp[6+i] = st_ff[k-1].u[i]  * st_ff[k-1].eye[i];
            end
         end
      end else if (k == ST_DS) begin : g_ds
         always_comb begin
            st_in[k] = st_ff[k-1];
            for (int r = 0; r < 3; r++) begin
               st_in[k].ds[r] = st_ff[k-1].dp[3*r] + st_ff[k-1].dp[3*r+1]
                              + st_ff[k-1].dp[3*r+2];
            end
         end
      end else if (k == ST_DR) begin : g_dr
         always_comb begin
            st_in[k] = st_ff[k-1];
            for (int r = 0; r < 3; r++) st_in[k].dr[r] = rnd_s(st_ff[k-1].ds[r]);
         end
      end else begin : g_sat
         always_comb begin
            logic signed [DRW:0] w;
            st_in[k] = st_ff[k-1];
            for (int r = 0; r < 3; r++) begin
               w = (r == 2) ? {st_ff[k-1].dr[r][DRW-1], st_ff[k-1].dr[r]}
                            : -{st_ff[k-1].dr[r][DRW-1], st_ff[k-1].dr[r]};
               if (w > TR_MAX) begin
                  st_in[k].tr[r]  = TR_MAX[31:0];
                  st_in[k].sat[r] = 1'b1;
               end else if (w < TR_MIN) begin
                  st_in[k].tr[r]  = TR_MIN[31:0];
                  st_in[k].sat[r] = 1'b1;
               end else begin
                  st_in[k].tr[r]  = w[31:0];
                  st_in[k].sat[r] = 1'b0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NST-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         st_ff <= st_in;
      end
      if (take) begin
         ser_ff <= st_ff[NST-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_vld_ff <= 1'b0;
         row_ff     <= lavm_pkg::ROW_LEFT;
      end else if (take) begin
         ser_vld_ff <= 1'b1;
         row_ff     <= lavm_pkg::ROW_LEFT;
      end else if (ser_vld_ff && !rsp_stall) begin
         row_ff <= lavm_pkg::row_type'(row_ff + 2'd1);
         if (row_ff == lavm_pkg::ROW_LAST) ser_vld_ff <= 1'b0;
      end
   end

   always_comb begin
      rsp_col0      = '0;
      rsp_col1      = '0;
      rsp_col2      = '0;
      rsp_col3      = '0;
      rsp_saturated = 1'b0;
      case (row_ff)
         lavm_pkg::ROW_LEFT: begin
            rsp_col0      = 32'(ser_ff.lf[0]);
            rsp_col1      = 32'(ser_ff.lf[1]);
            rsp_col2      = 32'(ser_ff.lf[2]);
            rsp_col3      = ser_ff.tr[0];
            rsp_saturated = ser_ff.sat[0];
         end
         lavm_pkg::ROW_UP: begin
            rsp_col0      = 32'(ser_ff.tu[0]);
            rsp_col1      = 32'(ser_ff.tu[1]);
            rsp_col2      = 32'(ser_ff.tu[2]);
            rsp_col3      = ser_ff.tr[1];
            rsp_saturated = ser_ff.sat[1];
         end
         lavm_pkg::ROW_FWD: begin
            rsp_col0      = 32'(-ser_ff.u[0]);
            rsp_col1      = 32'(-ser_ff.u[1]);
            rsp_col2      = 32'(-ser_ff.u[2]);
            rsp_col3      = ser_ff.tr[2];
            rsp_saturated = ser_ff.sat[2];
         end
         lavm_pkg::ROW_LAST: begin
            rsp_col3 = ONE;
         end
         default: begin
            rsp_col3 = '0;
         end
      endcase
      if (ser_ff.degen && row_ff != lavm_pkg::ROW_LAST) begin
         rsp_col0      = '0;
         rsp_col1      = '0;
         rsp_col2      = '0;
         rsp_col3      = '0;
         rsp_saturated = 1'b0;
      end
   end

   assign rsp_valid      = ser_vld_ff;
   assign rsp_row_index  = row_ff;
   assign rsp_degenerate = ser_ff.degen;
   assign rsp_last_row   = (row_ff == lavm_pkg::ROW_LAST);

   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> vld_ff[ST_IN])
      else $error("accepted req beat did not enter the pipeline");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(vld_ff))
      else $error("pipeline valids moved while frozen");

   a_take_starts_row0: assert property (@(posedge clock) disable iff (reset)
      take |=> rsp_valid && rsp_row_index == lavm_pkg::ROW_LEFT)
      else $error("new matrix did not start at row 0");

   a_row_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last_row && !take |=>
         rsp_valid && rsp_row_index == 2'($past(rsp_row_index) + 2'd1))
      else $error("row sequence broken");

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for the look-at view matrix builder.
module tb_top;

   localparam int FRAC = 16;
   localparam int WATCH_LIMIT = 20000;

   typedef struct packed {
      logic [1:0]         row_index;
      logic signed [31:0] col0;
      logic signed [31:0] col1;
      logic signed [31:0] col2;
      logic signed [31:0] col3;
      logic               degenerate;
      logic               saturated;
      logic               last_row;
   } row_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_eye_x = '0, req_eye_y = '0, req_eye_z = '0;
   logic signed [31:0] req_target_x = '0, req_target_y = '0, req_target_z = '0;
   logic signed [31:0] req_upward_x = '0, req_upward_y = '0, req_upward_z = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic [1:0] rsp_row_index;
   logic signed [31:0] rsp_col0, rsp_col1, rsp_col2, rsp_col3;
   logic rsp_degenerate, rsp_saturated, rsp_last_row;

   row_beat_type expected_rows[$];
   int  errors = 0;
   int  idle_pct = 12;
   int  quiet_cycles = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   look_at_view_matrix #(.FRAC_BITS(FRAC)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_eye_x(req_eye_x), .req_eye_y(req_eye_y), .req_eye_z(req_eye_z),
      .req_target_x(req_target_x), .req_target_y(req_target_y),
      .req_target_z(req_target_z),
      .req_upward_x(req_upward_x), .req_upward_y(req_upward_y),
      .req_upward_z(req_upward_z),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_row_index(rsp_row_index),
      .rsp_col0(rsp_col0), .rsp_col1(rsp_col1), .rsp_col2(rsp_col2),
      .rsp_col3(rsp_col3), .rsp_degenerate(rsp_degenerate),
      .rsp_saturated(rsp_saturated), .rsp_last_row(rsp_last_row)
   );

   function automatic longint round_q(longint v);
      longint m;
      m = (v < 0) ? -v : v;
      m = (m + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
      return (v < 0) ? -m : m;
   endfunction

   function automatic longint clamp32(longint v, inout logic flag);
      if (v > 64'sd2147483647) begin
         flag = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         flag = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic logic unit_vec(input longint v[3], output longint u[3]);
      longint unsigned m[3], mx, sum, len, q;
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
         if (m[i] > mx) mx = m[i];
         u[i] = 0;
      end
      if (mx == 0) return 1'b0;
      while (mx >= (64'd1 << 30)) begin
         for (int i = 0; i < 3; i++) m[i] >>= 1;
         mx >>= 1;
      end
      while (mx < (64'd1 << 29)) begin
         for (int i = 0; i < 3; i++) m[i] <<= 1;
         mx <<= 1;
      end
      sum = 0;
      for (int i = 0; i < 3; i++) sum += m[i] * m[i];
      len = int_sqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = ((m[i] << FRAC) * 2 + len) / (2 * len);
         u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
      return 1'b1;
   endfunction

   function automatic void cross_q(input longint a[3], input longint b[3],
                                   output longint r[3]);
      r[0] = round_q(a[1] * b[2] - a[2] * b[1]);
      r[1] = round_q(a[2] * b[0] - a[0] * b[2]);
      r[2] = round_q(a[0] * b[1] - a[1] * b[0]);
   endfunction

   function automatic longint dot_q(input longint a[3], input longint b[3]);
      return round_q(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
   endfunction

   function automatic row_beat_type make_row(lavm_pkg::row_type r, longint c0, longint c1,
                                             longint c2, longint c3, logic dg, logic st);
      row_beat_type b;
      b.row_index = r;
      b.col0 = c0[31:0];
      b.col1 = c1[31:0];
      b.col2 = c2[31:0];
      b.col3 = c3[31:0];
      b.degenerate = dg;
      b.saturated = st;
      b.last_row = (r == lavm_pkg::ROW_LAST);
      return b;
   endfunction

   // build the four view-matrix rows for one camera
   task automatic predict_view_rows(input logic signed [31:0] e[3],
                                    input logic signed [31:0] t[3],
                                    input logic signed [31:0] w[3]);
      longint eye[3], dir[3], up[3], fwd[3], upn[3], lft[3], tup[3];
      logic ok_f, ok_u, st;
      longint c3;
      for (int i = 0; i < 3; i++) begin
         eye[i] = e[i];
         dir[i] = longint'(t[i]) - longint'(e[i]);
         up[i] = w[i];
      end
      ok_f = unit_vec(dir, fwd);
      ok_u = unit_vec(up, upn);
      if (!(ok_f && ok_u)) begin
         expected_rows.push_back(make_row(lavm_pkg::ROW_LEFT, 0, 0, 0, 0, 1'b1, 1'b0));
         expected_rows.push_back(make_row(lavm_pkg::ROW_UP, 0, 0, 0, 0, 1'b1, 1'b0));
         expected_rows.push_back(make_row(lavm_pkg::ROW_FWD, 0, 0, 0, 0, 1'b1, 1'b0));
      end else begin
         cross_q(fwd, upn, lft);
         cross_q(lft, fwd, tup);
         st = 1'b0;
         c3 = clamp32(-dot_q(lft, eye), st);
         expected_rows.push_back(make_row(lavm_pkg::ROW_LEFT, lft[0], lft[1], lft[2], c3,
                                          1'b0, st));
         st = 1'b0;
         c3 = clamp32(-dot_q(tup, eye), st);
         expected_rows.push_back(make_row(lavm_pkg::ROW_UP, tup[0], tup[1], tup[2], c3,
                                          1'b0, st));
         st = 1'b0;
         c3 = clamp32(dot_q(fwd, eye), st);
         expected_rows.push_back(make_row(lavm_pkg::ROW_FWD, -fwd[0], -fwd[1], -fwd[2], c3,
                                          1'b0, st));
      end
      expected_rows.push_back(make_row(lavm_pkg::ROW_LAST, 0, 0, 0, 64'sd1 <<< FRAC,
                                       !(ok_f && ok_u), 1'b0));
   endtask

   task automatic send_camera(input logic signed [31:0] e[3],
                              input logic signed [31:0] t[3],
                              input logic signed [31:0] w[3]);
      while (($urandom_range(99) < idle_pct)) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_eye_x <= e[0]; req_eye_y <= e[1]; req_eye_z <= e[2];
      req_target_x <= t[0]; req_target_y <= t[1]; req_target_z <= t[2];
      req_upward_x <= w[0]; req_upward_y <= w[1]; req_upward_z <= w[2];
      predict_view_rows(e, t, w);
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom;
         1: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
         2: return $signed($urandom_range(32'h0200_0000)) - 32'sh0100_0000;
         default: begin
            case ($urandom_range(3))
               0: return 32'sh7fff_ffff;
               1: return 32'sh8000_0000;
               2: return 32'sh0;
               default: return $urandom_range(3) - 1;
            endcase
         end
      endcase
   endfunction

   task automatic test_directed();
      logic signed [31:0] e[3], t[3], w[3];
      // plain camera looking down -z, y up
      e = '{0, 0, 32'sh0005_0000}; t = '{0, 0, 0}; w = '{0, 32'sh0001_0000, 0};
      send_camera(e, t, w);
      // target equals eye
      e = '{32'sh0001_0000, 2, 3}; t = e; w = '{0, 32'sh0001_0000, 0};
      send_camera(e, t, w);
      // zero up vector
      e = '{0, 0, 0}; t = '{32'sh0001_0000, 0, 0}; w = '{0, 0, 0};
      send_camera(e, t, w);
      // both zero
      e = '{5, 5, 5}; t = e; w = '{0, 0, 0};
      send_camera(e, t, w);
      // extreme positions, max difference
      e = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
      t = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
      w = '{32'sh8000_0000, 32'sh7fff_ffff, 0};
      send_camera(e, t, w);
      e = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff};
      t = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000};
      w = '{1, 0, 32'shffff_ffff};
      send_camera(e, t, w);
      // up parallel to forward
      e = '{0, 0, 0}; t = '{0, 32'sh0003_0000, 0}; w = '{0, 7, 0};
      send_camera(e, t, w);
      // translation far away, saturating col3
      e = '{32'sh7fff_0000, 32'sh7fff_0000, 32'sh7fff_0000};
      t = '{32'sh7fff_0000, 32'sh7ffe_0000, 32'sh7fff_0000};
      w = '{32'sh0001_0000, 0, 32'sh0001_0000};
      send_camera(e, t, w);
      e = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000};
      t = '{32'sh8001_0000, 32'sh8001_0000, 32'sh8000_0000};
      w = '{0, 0, 32'sh8000_0000};
      send_camera(e, t, w);
      // tiny vectors
      e = '{0, 0, 0}; t = '{1, 0, 0}; w = '{0, 0, 32'shffff_ffff};
      send_camera(e, t, w);
      e = '{32'shffff_ffff, 32'shffff_ffff, 32'shffff_ffff}; t = '{0, 0, 0};
      w = '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff};
      send_camera(e, t, w);
      for (int k = 0; k < 8; k++) begin
         for (int i = 0; i < 3; i++) begin
            e[i] = rand_coord(3); t[i] = rand_coord(3); w[i] = rand_coord(3);
         end
         send_camera(e, t, w);
      end
   endtask

   task automatic test_random_cameras(int count);
      logic signed [31:0] e[3], t[3], w[3];
      int mode;
      for (int n = 0; n < count; n++) begin
         // quiet stretch with no idling on either side
         idle_pct = (n >= 150 && n < 230) ? 0 : 12;
         mode = $urandom_range(3);
         for (int i = 0; i < 3; i++) begin
            e[i] = rand_coord(mode);
            t[i] = rand_coord(($urandom_range(7) == 0) ? 3 : mode);
            w[i] = rand_coord($urandom_range(3));
         end
         if ($urandom_range(19) == 0) t = e;
         if ($urandom_range(19) == 0) w = '{0, 0, 0};
         send_camera(e, t, w);
      end
      idle_pct = 12;
   endtask

   always @(negedge clock) begin
      if (!reset) rsp_stall <= ($urandom_range(99) < idle_pct);
   end

   always @(posedge clock) begin
      row_beat_type exp_b;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (expected_rows.size() == 0) begin
               $error("unexpected row beat %0d", rsp_row_index);
               errors++;
            end else begin
               exp_b = expected_rows.pop_front();
               if (rsp_row_index !== exp_b.row_index) begin
                  $error("row_index exp %0d got %0d", exp_b.row_index, rsp_row_index);
                  errors++;
               end
               if (rsp_col0 !== exp_b.col0) begin
                  $error("col0 exp %h got %h", exp_b.col0, rsp_col0);
                  errors++;
               end
               if (rsp_col1 !== exp_b.col1) begin
                  $error("col1 exp %h got %h", exp_b.col1, rsp_col1);
                  errors++;
               end
               if (rsp_col2 !== exp_b.col2) begin
                  $error("col2 exp %h got %h", exp_b.col2, rsp_col2);
                  errors++;
               end
               if (rsp_col3 !== exp_b.col3) begin
                  $error("col3 exp %h got %h", exp_b.col3, rsp_col3);
                  errors++;
               end
               if (rsp_degenerate !== exp_b.degenerate) begin
                  $error("degenerate exp %b got %b", exp_b.degenerate, rsp_degenerate);
                  errors++;
               end
               if (rsp_saturated !== exp_b.saturated) begin
                  $error("saturated exp %b got %b", exp_b.saturated, rsp_saturated);
                  errors++;
               end
               if (rsp_last_row !== exp_b.last_row) begin
                  $error("last_row exp %b got %b", exp_b.last_row, rsp_last_row);
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (quiet_cycles >= WATCH_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_cameras(400);
      req_valid <= 1'b0;
      while (expected_rows.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      if (errors == 0 && expected_rows.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/lavm_pkg.sv
rtl/look_at_view_matrix.sv
tb/tb_top.sv
